// ===== hw/rtl/tql_pkg.sv =====
package tql_pkg;

  // default table size
  localparam int NUM_STATES_DEF  = 4;
  localparam int NUM_ACTIONS_DEF = 7;

  // field widths
  localparam int REQ_W    = 2;
  localparam int STATE_W  = 2;
  localparam int ACTION_W = 3;
  localparam int REWARD_W = 16;
  localparam int PCT_W    = 7;
  localparam int Q_W      = 32;
  localparam int FRAC_W   = 16;

  // input tdata layout, lowest bit first
  localparam int IN_ROW_LSB   = 0;
  localparam int IN_NXT_LSB   = IN_ROW_LSB + STATE_W;
  localparam int IN_COL_LSB   = IN_NXT_LSB + STATE_W;
  localparam int IN_RWD_LSB   = IN_COL_LSB + ACTION_W;
  localparam int IN_PCT_LSB   = IN_RWD_LSB + REWARD_W;
  localparam int IN_RACT_LSB  = IN_PCT_LSB + PCT_W;
  localparam int IN_ENTRY_LSB = IN_RACT_LSB + ACTION_W;
  localparam int IN_USED_W    = IN_ENTRY_LSB + Q_W;
  localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // output tdata layout, lowest bit first
  localparam int OUT_ACT_LSB  = 0;
  localparam int OUT_RAND_LSB = OUT_ACT_LSB + ACTION_W;
  localparam int OUT_Q_LSB    = OUT_RAND_LSB + 1;
  localparam int OUT_SAT_LSB  = OUT_Q_LSB + Q_W;
  localparam int OUT_USED_W   = OUT_SAT_LSB + 1;
  localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_PERCENT = 2'd2;

  localparam logic [FRAC_W-1:0] LEARNING_RATE_RST   = 16'd6554;
  localparam logic [FRAC_W-1:0] DISCOUNT_FACTOR_RST = 16'd58982;
  localparam logic [PCT_W-1:0]  EXPLORE_PERCENT_RST = 7'd10;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [REQ_W-1:0] {
    REQ_CHOOSE = 2'd0,
    REQ_UPDATE = 2'd1,
    REQ_WRITE  = 2'd2,
    REQ_READ   = 2'd3
  } req_type_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic clr_step;
    logic scan_rd;
    logic cap_old;
    logic wr_entry;
    logic cap_rd;
    logic sum_wr;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    req_type_t req;
    logic      row_ok;
    logic      cell_ok;
    logic      nxt_ok;
    logic      scan_last;
    logic      clr_last;
  } sts_t;

endpackage

// ===== hw/rtl/tql_ram.sv =====
module tql_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 28
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/tql_ctrl.sv =====
module tql_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  tql_pkg::sts_t sts,
  output tql_pkg::cmd_t cmd
);

  import tql_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_SCAN_END,
    S_OLD_RD,
    S_MUL1,
    S_TGT,
    S_DIFF,
    S_MUL2,
    S_SUM,
    S_WR,
    S_RD,
    S_RD_WAIT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   load;

  assign load = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DISP;
      end
      S_DISP: begin
        case (sts.req)
          REQ_CHOOSE: state_nxt = sts.row_ok ? S_SCAN : S_DONE;
          REQ_UPDATE: state_nxt = (sts.cell_ok && sts.nxt_ok) ? S_SCAN : S_DONE;
          REQ_WRITE:  state_nxt = sts.cell_ok ? S_WR : S_DONE;
          REQ_READ:   state_nxt = sts.cell_ok ? S_RD : S_DONE;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (sts.scan_last) state_nxt = S_SCAN_END;
      end
      // last compare lands here
      S_SCAN_END: state_nxt = (sts.req == REQ_UPDATE) ? S_OLD_RD : S_DONE;
      S_OLD_RD:   state_nxt = S_MUL1;
      S_MUL1:     state_nxt = S_TGT;
      S_TGT:      state_nxt = S_DIFF;
      S_DIFF:     state_nxt = S_MUL2;
      S_MUL2:     state_nxt = S_SUM;
      S_SUM:      state_nxt = S_DONE;
      S_WR:       state_nxt = S_DONE;
      S_RD:       state_nxt = S_RD_WAIT;
      S_RD_WAIT:  state_nxt = S_DONE;
      S_DONE: begin
        if (load) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.latch_in = (state_r == S_IDLE) && in_tvalid;
    cmd.clr_step = (state_r == S_CLEAR);
    cmd.scan_rd  = (state_r == S_SCAN);
    cmd.cap_old  = (state_r == S_MUL1);
    cmd.wr_entry = (state_r == S_WR);
    cmd.cap_rd   = (state_r == S_RD_WAIT);
    cmd.sum_wr   = (state_r == S_SUM);
    cmd.load_out = load;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

endmodule

// ===== hw/rtl/tql_dp.sv =====
module tql_dp #(
  parameter int NUM_STATES  = tql_pkg::NUM_STATES_DEF,
  parameter int NUM_ACTIONS = tql_pkg::NUM_ACTIONS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [tql_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [tql_pkg::REQ_W-1:0]        in_tuser,
  input  logic                             cfg_valid,
  input  logic [tql_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tql_pkg::FRAC_W-1:0]       cfg_data,
  input  tql_pkg::cmd_t                    cmd,
  output tql_pkg::sts_t                    sts,
  output logic [tql_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  import tql_pkg::*;

  localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(NUM_ACTIONS);

  // random action reduced modulo the action count, at most four subtractions
  function automatic logic [ACTION_W-1:0] act_mod(input logic [ACTION_W-1:0] a);
    logic [6:0] r;
    r = 7'(a);
    for (int k = 0; k < 4; k++) begin
      if (r >= 7'(NUM_ACTIONS)) r = r - 7'(NUM_ACTIONS);
    end
    return r[ACTION_W-1:0];
  endfunction

  // configuration
  logic [FRAC_W-1:0] alpha_r, gamma_r;
  logic [PCT_W-1:0]  eps_r;

  // latched request
  req_type_t                   req_r;
  logic [STATE_W-1:0]          row_r, nxt_r;
  logic [ACTION_W-1:0]         col_r, ract_r;
  logic signed [REWARD_W-1:0]  reward_r;
  logic [Q_W-1:0]              entry_r;
  logic                        rand_r;

  // row scan
  logic [IW-1:0]               idx_r, cmp_idx_r, g_r;
  logic                        cmp_vld_r;
  logic signed [Q_W-1:0]       best_r;
  logic [AW-1:0]               clr_addr_r;

  // update arithmetic
  logic signed [Q_W-1:0]       old_r;
  logic signed [48:0]          p1_r;
  logic signed [34:0]          tgt_r, diff_r;
  logic signed [51:0]          p2_r;

  logic [Q_W-1:0]              res_q_r;
  logic                        res_sat_r;

  logic [ACTION_W-1:0]         out_act_r;
  logic                        out_rand_r, out_sat_r;
  logic [Q_W-1:0]              out_q_r;

  logic                        row_ok, col_ok, nxt_ok;
  logic [STATE_W-1:0]          srow;
  logic [AW-1:0]               cell_addr, scan_addr, raddr, waddr;
  logic [Q_W-1:0]              rdata, wdata;
  logic                        we;

  logic signed [48:0]          p1_nxt;
  logic signed [32:0]          t1;
  logic signed [34:0]          tgt_nxt, diff_nxt;
  logic signed [51:0]          p2_nxt;
  logic signed [36:0]          t2, nv_wide;
  logic signed [Q_W-1:0]       nv_sat;
  logic                        nv_clip;

  assign row_ok    = int'(row_r) < NUM_STATES;
  assign col_ok    = int'(col_r) < NUM_ACTIONS;
  assign nxt_ok    = int'(nxt_r) < NUM_STATES;
  assign srow      = (req_r == REQ_UPDATE) ? nxt_r : row_r;
  assign cell_addr = AW'(int'(row_r) * NUM_ACTIONS + int'(col_r));
  assign scan_addr = AW'(int'(srow) * NUM_ACTIONS + int'(idx_r));

  always_comb begin
    sts           = '0;
    sts.req       = req_r;
    sts.row_ok    = row_ok;
    sts.cell_ok   = row_ok && col_ok;
    sts.nxt_ok    = nxt_ok;
    sts.scan_last = int'(idx_r) == NUM_ACTIONS - 1;
    sts.clr_last  = int'(clr_addr_r) == DEPTH - 1;
  end

  // fixed point: round half up after each 0.16 product, clip the final sum
  always_comb begin
    p1_nxt   = 49'(best_r) * 49'($signed({1'b0, gamma_r}));
    t1       = 33'((p1_r + 49'sd32768) >>> FRAC_W);
    tgt_nxt  = 35'($signed({reward_r, 16'b0})) + 35'(t1);
    diff_nxt = tgt_r - 35'(old_r);
    p2_nxt   = 52'(diff_r) * 52'($signed({1'b0, alpha_r}));
    t2       = 37'((p2_r + 52'sd32768) >>> FRAC_W);
    nv_wide  = 37'(old_r) + t2;
    nv_clip  = 1'b0;
    nv_sat   = nv_wide[Q_W-1:0];
    if (nv_wide > 37'(Q_MAX)) begin
      nv_sat  = Q_MAX;
      nv_clip = 1'b1;
    end else if (nv_wide < 37'(Q_MIN)) begin
      nv_sat  = Q_MIN;
      nv_clip = 1'b1;
    end
  end

  assign raddr = cmd.scan_rd ? scan_addr : cell_addr;
  assign we    = cmd.clr_step || cmd.wr_entry || cmd.sum_wr;
  assign waddr = cmd.clr_step ? clr_addr_r : cell_addr;
  assign wdata = cmd.clr_step ? '0 : (cmd.wr_entry ? entry_r : nv_sat);

  tql_ram #(
    .WIDTH (Q_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r    <= LEARNING_RATE_RST;
      gamma_r    <= DISCOUNT_FACTOR_RST;
      eps_r      <= EXPLORE_PERCENT_RST;
      clr_addr_r <= '0;
      cmp_vld_r  <= 1'b0;
      idx_r      <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LEARNING_RATE:   alpha_r <= cfg_data;
          CFG_DISCOUNT_FACTOR: gamma_r <= cfg_data;
          CFG_EXPLORE_PERCENT: eps_r   <= cfg_data[PCT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_step) clr_addr_r <= clr_addr_r + AW'(1);
      cmp_vld_r <= cmd.scan_rd;
      if (cmd.latch_in) begin
        idx_r <= '0;
      end else if (cmd.scan_rd) begin
        idx_r <= idx_r + IW'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r    <= req_type_t'(in_tuser);
      row_r    <= in_tdata[IN_ROW_LSB +: STATE_W];
      nxt_r    <= in_tdata[IN_NXT_LSB +: STATE_W];
      col_r    <= in_tdata[IN_COL_LSB +: ACTION_W];
      reward_r <= $signed(in_tdata[IN_RWD_LSB +: REWARD_W]);
      entry_r  <= in_tdata[IN_ENTRY_LSB +: Q_W];
      rand_r   <= in_tdata[IN_PCT_LSB +: PCT_W] < eps_r;
      ract_r   <= act_mod(in_tdata[IN_RACT_LSB +: ACTION_W]);
    end

    // read data arrives in the cycle after the scan address, so cmp_idx_r follows idx_r
    cmp_idx_r <= idx_r;
    if (cmp_vld_r && ((cmp_idx_r == '0) || ($signed(rdata) > best_r))) begin
      best_r <= $signed(rdata);
      g_r    <= cmp_idx_r;
    end

    if (cmd.cap_old) old_r <= $signed(rdata);
    p1_r   <= p1_nxt;
    tgt_r  <= tgt_nxt;
    diff_r <= diff_nxt;
    p2_r   <= p2_nxt;

    if (cmd.latch_in) begin
      res_q_r   <= '0;
      res_sat_r <= 1'b0;
    end else if (cmd.wr_entry) begin
      res_q_r <= entry_r;
    end else if (cmd.cap_rd) begin
      res_q_r <= rdata;
    end else if (cmd.sum_wr) begin
      res_q_r   <= nv_sat;
      res_sat_r <= nv_clip;
    end

    if (cmd.load_out) begin
      if (req_r == REQ_CHOOSE) begin
        // a row off the table has no scan, greedy action is 0
        out_act_r  <= rand_r ? ract_r : (row_ok ? ACTION_W'(g_r) : '0);
        out_rand_r <= rand_r;
        out_q_r    <= row_ok ? best_r : '0;
        out_sat_r  <= 1'b0;
      end else begin
        out_act_r  <= '0;
        out_rand_r <= 1'b0;
        out_q_r    <= res_q_r;
        out_sat_r  <= res_sat_r;
      end
    end
  end

  assign out_tdata = {(OUT_TDATA_W - OUT_USED_W)'(0), out_sat_r, out_q_r, out_rand_r, out_act_r};

endmodule

// ===== hw/rtl/tabular_q_learning_engine_core.sv =====
// choose scans the state_index row; update scans the next_state row, then reads the old entry,
// multiplies, sums and writes it back; write and read touch one cell. One request at a time, the
// next accepted once the result is registered; a result waits until out_tready took the last one
// the row scan reads one table entry per cycle through the single read port of the table ram
// rst_n (synchronous) starts a clearing pass that zeroes every table entry and holds in_tready
// low; configuration returns to its defaults
module tabular_q_learning_engine_core #(
  parameter int NUM_STATES  = tql_pkg::NUM_STATES_DEF,
  parameter int NUM_ACTIONS = tql_pkg::NUM_ACTIONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // state_index, next_state, action_index, reward_value, random_percent, random_action,
  // entry_value, zero pad
  input  logic [tql_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  logic [tql_pkg::REQ_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // chosen_action, was_random, q_value, saturated, zero pad
  output logic [tql_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tql_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tql_pkg::FRAC_W-1:0]      cfg_data
);

  import tql_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tql_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tql_dp #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // clearing pass keeps the input closed right after reset
  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input open during table clear");

  // only one source writes the table in a cycle
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_step, cmd.wr_entry, cmd.sum_wr}))
    else $error("table write conflict");

endmodule
